### hw/rtl/pjs_pkg.sv
`timescale 1ns / 1ps
// shared constants, job types and ordering function for the priority job scheduler
package pjs_pkg;

    localparam int MAX_JOBS = 64;
    localparam int ADDR_W   = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 23;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int TICK_W   = 16;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] arr;
        logic [TICK_W-1:0] bur;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] idx;
        t_job              job;
    } t_best;

    // strict ordering: lower priority value first, then earlier arrival
    function automatic logic goes_before(input t_job a, input t_job b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio < b.prio);
        end else begin
            res = (a.arr < b.arr);
        end
        return res;
    endfunction

endpackage

### hw/rtl/pjs_if.sv
`timescale 1ns / 1ps
// valid/ready channels for job loading and schedule results
interface pjs_job_if;
    logic        valid;
    logic        ready;
    logic [15:0] job_id;
    logic [7:0]  job_priority;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic        final_job;

    modport source (output valid, job_id, job_priority, arrival, burst, final_job,
                    input ready);
    modport sink   (input valid, job_id, job_priority, arrival, burst, final_job,
                    output ready);
endinterface

interface pjs_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] served_id;
    logic [22:0] completion;
    logic [22:0] turnaround;
    logic [22:0] waiting;
    logic        last_result;

    modport source (output valid, served_id, completion, turnaround, waiting, last_result,
                    input ready);
    modport sink   (input valid, served_id, completion, turnaround, waiting, last_result,
                    output ready);
endinterface

### hw/rtl/pjs_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module pjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pjs_pick.sv
`timescale 1ns / 1ps
// running minimum over one scan of the job store
module pjs_pick
    import pjs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_vld,
    input  logic              i_skip,
    input  logic [ADDR_W-1:0] i_idx,
    input  t_job              i_job,
    output t_best             o_best
);

    t_best r_best;
    logic  take;

    // ascending scan with a strict compare keeps load order among equal keys
    assign take = i_vld && !i_skip && (!r_best.found || goes_before(i_job, r_best.job));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best.idx <= i_idx;
            r_best.job <= i_job;
        end
        if (!i_rst_n) begin
            r_best.found <= 1'b0;
        end else if (i_clear) begin
            r_best.found <= 1'b0;
        end else if (take) begin
            r_best.found <= 1'b1;
        end
    end

    assign o_best = r_best;

endmodule

### hw/rtl/priority_job_scheduler.sv
`timescale 1ns / 1ps
// top level: job loading, selection scans over the job ram, timing and result register
//
//  channel   dir   payload                                           beat
//  i_job     in    job_id, job_priority, arrival, burst, final_job   one job
//  o_res     out   served_id, completion, turnaround, waiting,
//                  last_result                                       one served job
//
// jobs load at one beat per cycle while idle; the beat with final_job closes the set.
// each result then takes a scan with one ram read per stored job, followed by the
// drain, timing and emit steps; the single read port of the job ram serialises these
// reads, and no jobs are taken meanwhile. a stalled o_res holds the schedule in its
// emit step. reset is synchronous and needs no clearing pass: only entries written in
// the current set are read.
module priority_job_scheduler
    import pjs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pjs_job_if.sink   i_job,
    pjs_res_if.source o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]          r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_emitted;
    logic [TIME_W-1:0]   r_clk_now;
    logic [ADDR_W-1:0]   r_scan;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic [MAX_JOBS-1:0] r_served;
    logic [TIME_W-1:0]   r_done;
    logic [TIME_W-1:0]   r_wait;

    logic                r_o_valid;
    logic [ID_W-1:0]     r_o_id;
    logic [TIME_W-1:0]   r_o_completion;
    logic [TIME_W-1:0]   r_o_turnaround;
    logic [TIME_W-1:0]   r_o_waiting;
    logic                r_o_last;

    logic                job_acc;
    logic                store_en;
    t_job                in_job;
    logic [JOB_W-1:0]    rd_data;
    t_best               best;
    logic                pick_clear;
    logic                scan_last;
    logic                out_free;
    logic                emit;
    logic                emit_last;
    logic [TIME_W-1:0]   best_arr;
    logic [TIME_W-1:0]   best_bur;
    logic [TIME_W-1:0]   start;

    assign i_job.ready = (r_state == ST_IDLE);
    assign job_acc     = i_job.valid && i_job.ready;
    // a full store drops further jobs
    assign store_en    = job_acc && (r_count < CNT_W'(MAX_JOBS));

    assign in_job.id   = i_job.job_id;
    assign in_job.prio = i_job.job_priority;
    assign in_job.arr  = i_job.arrival;
    assign in_job.bur  = i_job.burst;

    // loads and scans never overlap, so no forwarding between the ports is needed
    pjs_ram #(
        .WIDTH (JOB_W),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (store_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (in_job),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (r_scan),
        .o_rdata (rd_data)
    );

    assign out_free   = !r_o_valid || o_res.ready;
    assign emit       = (r_state == ST_EMIT) && out_free;
    assign emit_last  = (r_emitted + 1'b1) == r_count;
    assign pick_clear = emit || (job_acc && i_job.final_job);

    pjs_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (pick_clear),
        .i_vld   (r_rd_vld),
        .i_skip  (r_served[r_rd_idx]),
        .i_idx   (r_rd_idx),
        .i_job   (t_job'(rd_data)),
        .o_best  (best)
    );

    assign scan_last = (CNT_W'(r_scan) + 1'b1) == r_count;
    assign best_arr  = TIME_W'(best.job.arr);
    assign best_bur  = TIME_W'(best.job.bur);
    // idle clock jumps forward to the arrival
    assign start     = (r_clk_now < best_arr) ? best_arr : r_clk_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_emitted <= '0;
            r_clk_now <= '0;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_served  <= '0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN);
            case (r_state)
                ST_IDLE: begin
                    if (job_acc) begin
                        r_count <= r_count + CNT_W'(store_en);
                        if (i_job.final_job) begin
                            r_state   <= ST_SCAN;
                            r_scan    <= '0;
                            r_emitted <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (scan_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit) begin
                        r_served[best.idx] <= 1'b1;
                        r_emitted          <= r_emitted + 1'b1;
                        r_clk_now          <= r_done;
                        r_scan             <= '0;
                        if (emit_last) begin
                            r_state   <= ST_IDLE;
                            r_count   <= '0;
                            r_clk_now <= '0;
                            r_served  <= '0;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan;
        if (r_state == ST_CALC) begin
            r_done <= start + best_bur;
            r_wait <= start - best_arr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_id         <= best.job.id;
            r_o_completion <= r_done;
            r_o_turnaround <= r_done - best_arr;
            r_o_waiting    <= r_wait;
            r_o_last       <= emit_last;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.served_id   = r_o_id;
    assign o_res.completion  = r_o_completion;
    assign o_res.turnaround  = r_o_turnaround;
    assign o_res.waiting     = r_o_waiting;
    assign o_res.last_result = r_o_last;

endmodule

### hw/rtl/pjs_checker.sv
`timescale 1ns / 1ps
// port-level checks for the priority job scheduler and their bind
module pjs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_job_valid,
    input logic        i_job_ready,
    input logic        i_job_final,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_res_id,
    input logic [22:0] i_res_completion,
    input logic [22:0] i_res_turnaround,
    input logic [22:0] i_res_waiting,
    input logic        i_res_last
);

    // a closing beat stops loading: ready drops once the beat is taken
    a_close_blocks_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid && i_job_ready && i_job_final |=> !i_job_ready)
        else $error("job taken right after the closing beat");

    // no new jobs while a non-final result is pending
    a_no_load_mid_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_last |-> !i_job_ready)
        else $error("loading while schedule still running");

    // times are ordered: waiting <= turnaround <= completion
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_waiting <= i_res_turnaround) &&
                        (i_res_turnaround <= i_res_completion))
        else $error("result times out of order");

    // stalled result beat holds its id, completion and last flag
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_id) &&
            $stable(i_res_completion) && $stable(i_res_last))
        else $error("stalled result beat changed");

endmodule

bind priority_job_scheduler pjs_checker u_pjs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_job_valid      (i_job.valid),
    .i_job_ready      (i_job.ready),
    .i_job_final      (i_job.final_job),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_id         (o_res.served_id),
    .i_res_completion (o_res.completion),
    .i_res_turnaround (o_res.turnaround),
    .i_res_waiting    (o_res.waiting),
    .i_res_last       (o_res.last_result)
);

### tb/priority_job_scheduler_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the priority job scheduler: directed and random job sets against a scoreboard
module priority_job_scheduler_test;
    import pjs_pkg::*;

    typedef struct packed {
        t_job job;
        logic closes_set;
    } t_load;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last;
    } t_served;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall;

    logic i_clk;
    logic i_rst_n;

    pjs_job_if job_ch ();
    pjs_res_if res_ch ();

    priority_job_scheduler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_ch),
        .o_res   (res_ch)
    );

    t_load   pending_loads[$];
    t_served served_q[$];
    t_job    loaded_jobs[MAX_JOBS];
    int      loaded_count;
    int      issued_count;
    int      fail_count;

    // sender burst state
    t_load   next_load;
    int      burst_left;
    int      gap_left;

    // receiver stall state
    t_stall      stall_mode;
    int          mode_left;
    logic [15:0] stall_pattern;

    t_served want;
    t_served got;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // store one accepted job; on the closing job order the set and time it
    function automatic void take_job(input t_load ld);
        t_job              ord[MAX_JOBS];
        t_job              key;
        int                j;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] done;
        logic [TIME_W-1:0] turn;
        t_served           r;
        if (loaded_count < MAX_JOBS) begin
            loaded_jobs[loaded_count] = ld.job;
            loaded_count++;
        end
        if (!ld.closes_set) return;
        for (int i = 0; i < loaded_count; i++) ord[i] = loaded_jobs[i];
        // stable insertion sort: priority, then arrival, ties keep load order
        for (int i = 1; i < loaded_count; i++) begin
            key = ord[i];
            j = i;
            while (j > 0 && (key.prio < ord[j-1].prio ||
                   (key.prio == ord[j-1].prio && key.arr < ord[j-1].arr))) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = key;
        end
        now = '0;
        for (int i = 0; i < loaded_count; i++) begin
            if (now < TIME_W'(ord[i].arr)) now = TIME_W'(ord[i].arr);
            done = now + TIME_W'(ord[i].bur);
            turn = done - TIME_W'(ord[i].arr);
            r.id         = ord[i].id;
            r.completion = done;
            r.turnaround = turn;
            r.waiting    = turn - TIME_W'(ord[i].bur);
            r.last       = (i == loaded_count - 1);
            served_q.push_back(r);
            now = done;
        end
        loaded_count = 0;
    endfunction

    function automatic void add_load(input logic [15:0] id, input logic [7:0] prio,
                                     input logic [15:0] arr, input logic [15:0] bur,
                                     input logic closes);
        t_load ld;
        ld.job.id   = id;
        ld.job.prio = prio;
        ld.job.arr  = arr;
        ld.job.bur  = bur;
        ld.closes_set = closes;
        pending_loads.push_back(ld);
        issued_count++;
    endfunction

    // style 0: full range, 1: dense ties and zero bursts, 2: mixed extremes, 3: arrival and burst at maximum
    function automatic void add_job_set(input int n, input int style);
        logic [7:0]  prio;
        logic [15:0] arr;
        logic [15:0] bur;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: begin
                    prio = 8'($urandom);
                    arr  = 16'($urandom);
                    bur  = 16'($urandom);
                end
                1: begin
                    prio = 8'($urandom_range(0, 3));
                    arr  = 16'($urandom_range(0, 20));
                    bur  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
                end
                2: begin
                    prio = ($urandom_range(0, 3) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                                       : 8'($urandom);
                    arr  = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                       : 16'($urandom_range(0, 2000));
                    case ($urandom_range(0, 3))
                        0:       bur = 16'd0;
                        1:       bur = 16'hffff;
                        default: bur = 16'($urandom_range(0, 500));
                    endcase
                end
                default: begin
                    prio = 8'($urandom);
                    arr  = 16'hffff;
                    bur  = 16'hffff;
                end
            endcase
            add_load(16'($urandom), prio, arr, bur, i == n - 1);
        end
    endfunction

    // sender: bursts of beats with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            job_ch.valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else if (!job_ch.valid || job_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                job_ch.valid <= 1'b0;
            end else if (pending_loads.size() != 0) begin
                next_load = pending_loads.pop_front();
                job_ch.valid        <= 1'b1;
                job_ch.job_id       <= next_load.job.id;
                job_ch.job_priority <= next_load.job.prio;
                job_ch.arrival      <= next_load.job.arr;
                job_ch.burst        <= next_load.job.bur;
                job_ch.final_job    <= next_load.closes_set;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                             : $urandom_range(0, 4);
                end
            end else begin
                job_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && job_ch.valid && job_ch.ready) begin
            take_job({job_ch.job_id, job_ch.job_priority, job_ch.arrival, job_ch.burst,
                      job_ch.final_job});
        end
    end

    // receiver: a randomly chosen stall mode drives ready and is redrawn when its run ends
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            mode_left = 0;
        end else begin
            if (mode_left <= 0) begin
                stall_mode    = t_stall'($urandom_range(0, 3));
                mode_left     = $urandom_range(40, 400);
                stall_pattern = 16'($urandom) | 16'h0001;
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:    res_ch.ready <= 1'b1;
                STALL_RANDOM:  res_ch.ready <= ($urandom_range(0, 3) != 0);
                STALL_PATTERN: begin
                    res_ch.ready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                end
                default:       res_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.served_id, res_ch.completion, res_ch.turnaround, res_ch.waiting,
                   res_ch.last_result};
            if (served_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: id %0d completion %0d", got.id,
                             got.completion);
                end
            end else begin
                want = served_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected id %0d cpl %0d tat %0d wait %0d last %0b",
                                 want.id, want.completion, want.turnaround, want.waiting,
                                 want.last);
                        $display("          actual   id %0d cpl %0d tat %0d wait %0d last %0b",
                                 got.id, got.completion, got.turnaround, got.waiting,
                                 got.last);
                    end
                end
            end
        end
    end

    initial begin
        int n;
        int pick;
        i_rst_n             = 1'b0;
        job_ch.valid        = 1'b0;
        job_ch.job_id       = '0;
        job_ch.job_priority = '0;
        job_ch.arrival      = '0;
        job_ch.burst        = '0;
        job_ch.final_job    = 1'b0;
        res_ch.ready        = 1'b0;
        loaded_count = 0;
        issued_count = 0;
        fail_count   = 0;

        // single-job sets at both ends of every field
        add_load(16'hffff, 8'hff, 16'hffff, 16'hffff, 1'b1);
        add_load(16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1);
        // ties in both keys, idle jumps, zero burst, late arrival served first
        add_load(16'h0101, 8'd5,   16'd100,   16'd10,    1'b0);
        add_load(16'h0202, 8'd5,   16'd100,   16'd0,     1'b0);
        add_load(16'h0303, 8'd5,   16'd40,    16'd7,     1'b0);
        add_load(16'h0404, 8'd2,   16'd500,   16'd3,     1'b0);
        add_load(16'h0505, 8'd9,   16'd0,     16'd20,    1'b0);
        add_load(16'h0606, 8'd5,   16'd100,   16'hffff,  1'b0);
        add_load(16'h0707, 8'd0,   16'hffff,  16'd1,     1'b0);
        add_load(16'h0808, 8'hff,  16'hffff,  16'd0,     1'b1);
        add_load(16'haaaa, 8'haa,  16'h5555,  16'haaaa,  1'b0);
        add_load(16'h5555, 8'h55,  16'haaaa,  16'h5555,  1'b1);
        // full store with every job at maximum arrival and burst: largest times
        add_job_set(MAX_JOBS, 3);

        while (issued_count < 430) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      n = $urandom_range(2, 8);
            else if (pick < 80) n = $urandom_range(9, 24);
            else if (pick < 88) n = 1;
            else if (pick < 94) n = MAX_JOBS;
            else                n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 6);
            add_job_set(n, $urandom_range(0, 2));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_loads.size() != 0 || job_ch.valid || served_q.size() != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        if (fail_count == 0 && served_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/pjs_pkg.sv
hw/rtl/pjs_if.sv
hw/rtl/pjs_ram.sv
hw/rtl/pjs_pick.sv
hw/rtl/priority_job_scheduler.sv
hw/rtl/pjs_checker.sv
tb/priority_job_scheduler_test.sv
